[rtl/tcte_pkg.sv]
package tcte_pkg;

   localparam int SOCKETS_DEF = 8;

   localparam logic [7:0] FLAG_FIN = 8'h01;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_RST = 8'h04;
   localparam logic [7:0] FLAG_PSH = 8'h08;
   localparam logic [7:0] FLAG_ACK = 8'h10;

   localparam logic [1:0] ST_FREE = 2'd0;
   localparam logic [1:0] ST_EST  = 2'd1;
   localparam logic [1:0] ST_CW   = 2'd2;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_SEND   = 2'd1;
   localparam logic [1:0] KIND_RESEND = 2'd2;
   localparam logic [1:0] KIND_NOTICE = 2'd3;

   localparam logic [1:0] OP_SEGMENT = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_WRITTEN = 2'd2;
   localparam logic [1:0] OP_CLOSE   = 2'd3;

   localparam logic [0:0] CSR_RESEND_TICKS = 1'd0;
   localparam logic [0:0] CSR_RETRY_LIMIT  = 1'd1;

   localparam logic [15:0] RESEND_TICKS_RST = 16'd20;
   localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd10;

   localparam logic [31:0] SYN_SEQ = 32'hAAAAAAAA;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] src_addr;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [31:0] seq_in;
      logic [31:0] ack_in;
      logic [7:0]  flags_in;
      logic [15:0] payload_len;
      logic [2:0]  syn_slot;
      logic        data_taken;
      logic [2:0]  conn;
      logic [7:0]  write_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic [7:0]  flags_out;
      logic [31:0] seq_out;
      logic [31:0] ack_out;
      logic [15:0] our_port;
      logic [15:0] peer_port;
      logic [31:0] peer_addr;
      logic        closing;
      logic        deliver;
      logic        last;
   } rsp_type;

endpackage

[rtl/tcte_req_if.sv]
interface tcte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] src_addr;
   logic [15:0] local_port;
   logic [15:0] remote_port;
   logic [31:0] seq_in;
   logic [31:0] ack_in;
   logic [7:0]  flags_in;
   logic [15:0] payload_len;
   logic [2:0]  syn_slot;
   logic        data_taken;
   logic [2:0]  conn;
   logic [7:0]  write_flags;

   modport source (output valid, op, src_addr, local_port, remote_port, seq_in, ack_in,
                   flags_in, payload_len, syn_slot, data_taken, conn, write_flags,
                   input ready);
   modport sink (input valid, op, src_addr, local_port, remote_port, seq_in, ack_in,
                 flags_in, payload_len, syn_slot, data_taken, conn, write_flags,
                 output ready);
endinterface

[rtl/tcte_rsp_if.sv]
interface tcte_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  slot;
   logic [7:0]  flags_out;
   logic [31:0] seq_out;
   logic [31:0] ack_out;
   logic [15:0] our_port;
   logic [15:0] peer_port;
   logic [31:0] peer_addr;
   logic        closing;
   logic        deliver;
   logic        last;

   modport source (output valid, kind, slot, flags_out, seq_out, ack_out, our_port,
                   peer_port, peer_addr, closing, deliver, last, input ready);
   modport sink (input valid, kind, slot, flags_out, seq_out, ack_out, our_port,
                 peer_port, peer_addr, closing, deliver, last, output ready);
endinterface

[rtl/tcp_connection_table_engine.sv]
// TCP connection table engine.
// req_chan takes one transaction per item: a parsed segment, a timer tick, an
// application write-done or a close request. rsp_chan returns response header
// descriptors; the final descriptor of an item carries last. A segment, a
// write-done and a close give exactly one descriptor, a tick one per slot that
// retransmits or times out, possibly none.
// The slot table is one memory read and written at one slot per cycle by a
// small sequencer; req_chan.ready is low while an item is in progress.
// A segment scans slots 1..SOCKETS-1 until one matches, reading and then
// checking each slot (SYN items skip the scan); a tick visits every slot
// the same way; write-done and close visit at most the slot that they name.
// Results pass through one output register, so the next item is accepted
// while a descriptor waits; a stalled receiver holds the sequencer only when
// a further descriptor has to be delivered.
// csr_we writes resend_ticks (index 0) or retry_limit (index 1); write only
// while idle. Reset frees every slot and restores the register defaults; no
// clearing pass is needed.
module tcp_connection_table_engine #(
   parameter int SOCKETS = tcte_pkg::SOCKETS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcte_req_if.sink    req_chan,
   tcte_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SW = $clog2(SOCKETS);
   localparam logic [SW-1:0] LAST_IDX = SW'(SOCKETS - 1);

   typedef struct packed {
      logic [1:0]  st;
      logic [15:0] own;
      logic [15:0] far;
      logic [31:0] addr;
      logic [31:0] sseq;
      logic [31:0] rack;
      logic [7:0]  lfl;
      logic [15:0] spay;
      logic [15:0] since;
      logic [7:0]  retry;
   } rec_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SRD, S_SCHK, S_ACK, S_SEG, S_WR0, S_SYN, S_REFUSE,
      S_TRD, S_TCHK, S_TPUSH, S_ORD, S_ODO, S_FLUSH
   } state_type;

   function automatic tcte_pkg::rsp_type hdr(rec_type w, logic [2:0] s, logic cl,
                                             logic dv);
      tcte_pkg::rsp_type r;
      r.kind      = tcte_pkg::KIND_SEND;
      r.slot      = s;
      r.flags_out = w.lfl;
      r.seq_out   = w.sseq;
      r.ack_out   = w.rack;
      r.our_port  = w.own;
      r.peer_port = w.far;
      r.peer_addr = w.addr;
      r.closing   = cl;
      r.deliver   = dv;
      r.last      = 1'b0;
      return r;
   endfunction

   function automatic tcte_pkg::rsp_type nothing(logic [2:0] s);
      tcte_pkg::rsp_type r;
      r      = '0;
      r.slot = s;
      return r;
   endfunction

   function automatic rec_type after_send(rec_type w);
      rec_type r;
      r      = w;
      r.spay = 16'd0;
      if ((w.lfl & (tcte_pkg::FLAG_PSH | tcte_pkg::FLAG_SYN | tcte_pkg::FLAG_FIN)) != 8'd0)
      begin
         r.since = 16'd1;
         r.retry = 8'd0;
      end
      return r;
   endfunction

   rec_type                mem [SOCKETS];
   logic [SOCKETS-1:0]     vld_ff;
   rec_type                rd_ff;
   logic                   rdv_ff;
   rec_type                rec_q;

   state_type              state_ff, state_in;
   logic [SW-1:0]          idx_ff, idx_in;
   tcte_pkg::req_type      req_ff, req_in, req_d;
   rec_type                wk_ff, wk_in;
   tcte_pkg::rsp_type      pend_ff, pend_in, hold_ff, hold_in, out_ff, out_in;
   logic                   pend_vld_ff, pend_vld_in, out_vld_ff, out_vld_in;
   logic [15:0]            resend_ff;
   logic [7:0]             limit_ff;

   logic                   mem_we;
   logic [SW-1:0]          mem_wa;
   rec_type                mem_wd;

   rec_type                nw;
   tcte_pkg::rsp_type      res;
   logic [31:0]            nxt;
   logic [15:0]            ns;
   logic                   drop, emit, out_free, grant_ok, match;

   assign req_d = '{op: req_chan.op, src_addr: req_chan.src_addr,
                    local_port: req_chan.local_port, remote_port: req_chan.remote_port,
                    seq_in: req_chan.seq_in, ack_in: req_chan.ack_in,
                    flags_in: req_chan.flags_in, payload_len: req_chan.payload_len,
                    syn_slot: req_chan.syn_slot, data_taken: req_chan.data_taken,
                    conn: req_chan.conn, write_flags: req_chan.write_flags};

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rec_q          = rdv_ff ? rd_ff : '0;
   assign out_free       = !out_vld_ff || rsp_chan.ready;
   assign grant_ok       = (req_ff.syn_slot != 3'd0) && (32'(req_ff.syn_slot) < SOCKETS);
   assign match          = (rec_q.st != tcte_pkg::ST_FREE) &&
                           (rec_q.own == req_ff.local_port) &&
                           (rec_q.far == req_ff.remote_port) &&
                           (rec_q.addr == req_ff.src_addr);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      req_in      = req_ff;
      wk_in       = wk_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      hold_in     = hold_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !rsp_chan.ready;
      mem_we      = 1'b0;
      mem_wa      = idx_ff;
      mem_wd      = rec_q;
      nw          = rec_q;
      res         = nothing(3'(idx_ff));
      nxt         = 32'd0;
      ns          = 16'd0;
      drop        = 1'b0;
      emit        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_in = req_d;
               unique case (req_d.op)
                  tcte_pkg::OP_SEGMENT: begin
                     if ((req_d.flags_in & tcte_pkg::FLAG_SYN) != 8'd0) begin
                        state_in = S_SYN;
                     end else begin
                        idx_in   = SW'(1);
                        state_in = S_SRD;
                     end
                  end
                  tcte_pkg::OP_TICK: begin
                     idx_in   = '0;
                     state_in = S_TRD;
                  end
                  default: begin
                     if (32'(req_d.conn) >= SOCKETS) begin
                        pend_in     = nothing(req_d.conn);
                        pend_vld_in = 1'b1;
                        state_in    = S_FLUSH;
                     end else begin
                        idx_in   = SW'(req_d.conn);
                        state_in = S_ORD;
                     end
                  end
               endcase
            end
         end
         S_SRD: state_in = S_SCHK;
         S_SCHK: begin
            if (match) begin
               wk_in    = rec_q;
               state_in = S_ACK;
            end else if (idx_ff == LAST_IDX) begin
               if ((req_ff.flags_in & (tcte_pkg::FLAG_PSH | tcte_pkg::FLAG_FIN)) != 8'd0) begin
                  state_in = S_REFUSE;
               end else begin
                  pend_in     = nothing(3'd0);
                  pend_vld_in = 1'b1;
                  state_in    = S_FLUSH;
               end
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = S_SRD;
            end
         end
         S_ACK: begin
            nxt = wk_ff.sseq + ((wk_ff.spay == 16'd0) ? 32'd1 : {16'd0, wk_ff.spay});
            if (((req_ff.flags_in & tcte_pkg::FLAG_RST) == 8'd0) &&
                ((req_ff.flags_in & tcte_pkg::FLAG_ACK) != 8'd0) &&
                (req_ff.ack_in[15:0] == nxt[15:0])) begin
               wk_in.since = 16'd0;
               wk_in.sseq  = nxt;
            end
            state_in = S_SEG;
         end
         S_SEG: begin
            nw       = wk_ff;
            state_in = S_FLUSH;
            if ((req_ff.flags_in & tcte_pkg::FLAG_RST) != 8'd0) begin
               nw.lfl = tcte_pkg::FLAG_RST | tcte_pkg::FLAG_ACK;
               nw.st  = tcte_pkg::ST_FREE;
               res    = hdr(nw, 3'(idx_ff), 1'b1, 1'b0);
               nw     = after_send(nw);
            end else if ((req_ff.flags_in & tcte_pkg::FLAG_FIN) != 8'd0) begin
               if (wk_ff.st == tcte_pkg::ST_CW) begin
                  nw.lfl  = tcte_pkg::FLAG_ACK;
                  nw.rack = req_ff.seq_in + 32'd1;
                  nw.st   = tcte_pkg::ST_FREE;
                  res     = hdr(nw, 3'(idx_ff), 1'b0, 1'b0);
               end else begin
                  nw.rack = wk_ff.rack + 32'd1;
                  nw.lfl  = tcte_pkg::FLAG_ACK | tcte_pkg::FLAG_FIN;
                  nw.st   = tcte_pkg::ST_CW;
                  res     = hdr(nw, 3'(idx_ff), 1'b1, 1'b0);
               end
               nw = after_send(nw);
            end else if (wk_ff.st == tcte_pkg::ST_CW) begin
               nw.st = tcte_pkg::ST_FREE;
               res   = hdr(nw, 3'(idx_ff), 1'b0, 1'b0);
               nw    = after_send(nw);
            end else if (req_ff.payload_len != 16'd0 && wk_ff.rack == req_ff.seq_in) begin
               nw.rack = wk_ff.rack + {16'd0, req_ff.payload_len};
               if (req_ff.data_taken) begin
                  res.kind    = tcte_pkg::KIND_NOTICE;
                  res.deliver = 1'b1;
               end else if (wk_ff.since != 16'd0) begin
                  res = '{kind: tcte_pkg::KIND_SEND, slot: 3'd0,
                          flags_out: tcte_pkg::FLAG_ACK, seq_out: nw.sseq,
                          ack_out: nw.rack, our_port: req_ff.local_port,
                          peer_port: req_ff.remote_port, peer_addr: req_ff.src_addr,
                          closing: 1'b0, deliver: 1'b1, last: 1'b0};
                  state_in = S_WR0;
               end else begin
                  nw.lfl = tcte_pkg::FLAG_ACK;
                  res    = hdr(nw, 3'(idx_ff), 1'b0, 1'b1);
                  nw     = after_send(nw);
               end
            end
            mem_we      = 1'b1;
            mem_wd      = nw;
            wk_in       = nw;
            pend_in     = res;
            pend_vld_in = 1'b1;
         end
         S_WR0: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = '{st: tcte_pkg::ST_FREE, own: req_ff.local_port,
                         far: req_ff.remote_port, addr: req_ff.src_addr,
                         sseq: wk_ff.sseq, rack: wk_ff.rack, lfl: tcte_pkg::FLAG_ACK,
                         spay: 16'd0, since: 16'd0, retry: 8'd0};
            state_in = S_FLUSH;
         end
         S_SYN: begin
            if (grant_ok) begin
               nw = '{st: tcte_pkg::ST_EST, own: req_ff.local_port,
                      far: req_ff.remote_port, addr: req_ff.src_addr,
                      sseq: tcte_pkg::SYN_SEQ, rack: req_ff.seq_in + 32'd1,
                      lfl: tcte_pkg::FLAG_SYN | tcte_pkg::FLAG_ACK,
                      spay: 16'd0, since: 16'd1, retry: 8'd0};
               pend_in     = hdr(nw, req_ff.syn_slot, 1'b0, 1'b0);
               pend_vld_in = 1'b1;
               nw.sseq     = tcte_pkg::SYN_SEQ + 32'd1;
               mem_we      = 1'b1;
               mem_wa      = SW'(req_ff.syn_slot);
               mem_wd      = nw;
               state_in    = S_FLUSH;
            end else begin
               state_in = S_REFUSE;
            end
         end
         S_REFUSE: begin
            nw = '{st: tcte_pkg::ST_FREE, own: req_ff.local_port,
                   far: req_ff.remote_port, addr: req_ff.src_addr,
                   sseq: req_ff.ack_in, rack: req_ff.seq_in,
                   lfl: tcte_pkg::FLAG_RST | tcte_pkg::FLAG_FIN | tcte_pkg::FLAG_ACK,
                   spay: 16'd0, since: 16'd1, retry: 8'd0};
            pend_in     = hdr(nw, 3'd0, 1'b0, 1'b0);
            pend_vld_in = 1'b1;
            mem_we      = 1'b1;
            mem_wa      = '0;
            mem_wd      = nw;
            state_in    = S_FLUSH;
         end
         S_TRD: state_in = S_TCHK;
         S_TCHK: begin
            if (rec_q.st != tcte_pkg::ST_FREE && rec_q.since != 16'd0) begin
               ns       = (rec_q.since == 16'hFFFF) ? rec_q.since : rec_q.since + 16'd1;
               nw.since = ns;
               if (ns > resend_ff) begin
                  emit = 1'b1;
                  if (rec_q.st == tcte_pkg::ST_CW) begin
                     nw.st       = tcte_pkg::ST_FREE;
                     res.kind    = tcte_pkg::KIND_NOTICE;
                     res.closing = 1'b1;
                  end else begin
                     nw.since = 16'd1;
                     drop     = rec_q.retry > limit_ff;
                     if (rec_q.retry != 8'hFF) begin
                        nw.retry = rec_q.retry + 8'd1;
                     end
                     if (drop) begin
                        nw.st = tcte_pkg::ST_FREE;
                     end
                     res         = hdr(rec_q, 3'(idx_ff), drop, 1'b0);
                     res.kind    = tcte_pkg::KIND_RESEND;
                     res.seq_out = 32'd0;
                     res.ack_out = 32'd0;
                  end
               end
               mem_we = 1'b1;
               mem_wd = nw;
            end
            if (emit && pend_vld_ff) begin
               hold_in  = res;
               state_in = S_TPUSH;
            end else begin
               if (emit) begin
                  pend_in     = res;
                  pend_vld_in = 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + SW'(1);
                  state_in = S_TRD;
               end
            end
         end
         S_TPUSH: begin
            if (out_free) begin
               out_in      = pend_ff;
               out_in.last = 1'b0;
               out_vld_in  = 1'b1;
               pend_in     = hold_ff;
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + SW'(1);
                  state_in = S_TRD;
               end
            end
         end
         S_ORD: state_in = S_ODO;
         S_ODO: begin
            state_in    = S_FLUSH;
            pend_vld_in = 1'b1;
            if (req_ff.op == tcte_pkg::OP_WRITTEN) begin
               nw.lfl  = req_ff.write_flags;
               pend_in = hdr(nw, 3'(idx_ff), 1'b0, 1'b0);
               nw      = after_send(nw);
               nw.spay = req_ff.payload_len;
               mem_we  = 1'b1;
               mem_wd  = nw;
            end else if (rec_q.st == tcte_pkg::ST_FREE || rec_q.st == tcte_pkg::ST_CW) begin
               pend_in = nothing(3'(idx_ff));
            end else begin
               nw.lfl  = tcte_pkg::FLAG_FIN | tcte_pkg::FLAG_ACK;
               nw.st   = tcte_pkg::ST_CW;
               pend_in = hdr(nw, 3'(idx_ff), 1'b0, 1'b0);
               nw      = after_send(nw);
               mem_we  = 1'b1;
               mem_wd  = nw;
            end
         end
         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in      = pend_ff;
               out_in.last = 1'b1;
               out_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rdv_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[mem_wa] <= 1'b1;
         end
         rdv_ff <= vld_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         resend_ff   <= tcte_pkg::RESEND_TICKS_RST;
         limit_ff    <= tcte_pkg::RETRY_LIMIT_RST;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               tcte_pkg::CSR_RESEND_TICKS: resend_ff <= csr_wdata;
               tcte_pkg::CSR_RETRY_LIMIT:  limit_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      idx_ff  <= idx_in;
      req_ff  <= req_in;
      wk_ff   <= wk_in;
      pend_ff <= pend_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.kind      = out_ff.kind;
   assign rsp_chan.slot      = out_ff.slot;
   assign rsp_chan.flags_out = out_ff.flags_out;
   assign rsp_chan.seq_out   = out_ff.seq_out;
   assign rsp_chan.ack_out   = out_ff.ack_out;
   assign rsp_chan.our_port  = out_ff.our_port;
   assign rsp_chan.peer_port = out_ff.peer_port;
   assign rsp_chan.peer_addr = out_ff.peer_addr;
   assign rsp_chan.closing   = out_ff.closing;
   assign rsp_chan.deliver   = out_ff.deliver;
   assign rsp_chan.last      = out_ff.last;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int NS = 8;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   tcte_req_if req_if ();
   tcte_rsp_if rsp_if ();

   tcp_connection_table_engine #(.SOCKETS(NS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // connection table copy
   logic [1:0]  slot_state   [NS];
   logic [15:0] slot_lport   [NS];
   logic [15:0] slot_rport   [NS];
   logic [31:0] slot_addr    [NS];
   logic [31:0] slot_snd     [NS];
   logic [31:0] slot_rcv     [NS];
   logic [7:0]  slot_flags   [NS];
   logic [15:0] slot_pay     [NS];
   logic [15:0] slot_age     [NS];
   logic [7:0]  slot_retries [NS];
   bit          slot_written [NS];
   logic [15:0] cfg_resend;
   logic [7:0]  cfg_retries;

   tcte_pkg::req_type pend_q[$];
   tcte_pkg::rsp_type header_q[$];
   tcte_pkg::rsp_type batch_q[$];
   int      errors;
   int      gap_cnt;
   int      burst_cnt;
   int      hold_cnt;
   int      hold_req;
   int      stall_mode;

   function automatic void emit(logic [1:0] k, int s, logic [7:0] fl, logic [31:0] sq,
                                logic [31:0] ak, logic [15:0] op, logic [15:0] pp,
                                logic [31:0] pa, logic cl, logic dv);
      tcte_pkg::rsp_type r;
      r.kind = k; r.slot = s[2:0]; r.flags_out = fl; r.seq_out = sq; r.ack_out = ak;
      r.our_port = op; r.peer_port = pp; r.peer_addr = pa;
      r.closing = cl; r.deliver = dv; r.last = 1'b0;
      batch_q.push_back(r);
   endfunction

   function automatic void send_header(int s, logic cl, logic dv);
      emit(tcte_pkg::KIND_SEND, s, slot_flags[s], slot_snd[s], slot_rcv[s], slot_lport[s],
           slot_rport[s], slot_addr[s], cl, dv);
      slot_pay[s] = '0;
      if (slot_flags[s] & (tcte_pkg::FLAG_PSH | tcte_pkg::FLAG_SYN | tcte_pkg::FLAG_FIN))
      begin
         slot_age[s] = 16'd1;
         slot_retries[s] = '0;
      end
   endfunction

   function automatic void refuse(tcte_pkg::req_type it);
      slot_rcv[0] = it.seq_in;
      slot_snd[0] = it.ack_in;
      slot_flags[0] = tcte_pkg::FLAG_RST | tcte_pkg::FLAG_FIN | tcte_pkg::FLAG_ACK;
      slot_state[0] = tcte_pkg::ST_FREE;
      slot_addr[0] = it.src_addr; slot_rport[0] = it.remote_port;
      slot_lport[0] = it.local_port;
      slot_written[0] = 1'b1;
      send_header(0, 1'b0, 1'b0);
   endfunction

   function automatic void segment_rx(tcte_pkg::req_type it);
      int r;
      logic [31:0] nxt;
      r = 0;
      for (int i = NS - 1; i >= 1; i--)
         if (slot_state[i] != tcte_pkg::ST_FREE && slot_lport[i] == it.local_port &&
             slot_rport[i] == it.remote_port && slot_addr[i] == it.src_addr)
            r = i;
      if (it.flags_in & tcte_pkg::FLAG_SYN) begin
         if (it.syn_slot != 0 && it.syn_slot < NS) begin
            r = int'(it.syn_slot);
            slot_lport[r] = it.local_port; slot_rport[r] = it.remote_port;
            slot_addr[r] = it.src_addr; slot_rcv[r] = it.seq_in + 32'd1;
            slot_snd[r] = tcte_pkg::SYN_SEQ; slot_state[r] = tcte_pkg::ST_EST;
            slot_age[r] = '0;
            slot_flags[r] = tcte_pkg::FLAG_SYN | tcte_pkg::FLAG_ACK;
            slot_written[r] = 1'b1;
            send_header(r, 1'b0, 1'b0);
            slot_snd[r] = slot_snd[r] + 32'd1;
         end else
            refuse(it);
         return;
      end
      if (r == 0) begin
         if (it.flags_in & (tcte_pkg::FLAG_PSH | tcte_pkg::FLAG_FIN)) refuse(it);
         else emit(tcte_pkg::KIND_NONE, 0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
         return;
      end
      if (it.flags_in & tcte_pkg::FLAG_RST) begin
         slot_flags[r] = tcte_pkg::FLAG_RST | tcte_pkg::FLAG_ACK;
         slot_state[r] = tcte_pkg::ST_FREE;
         send_header(r, 1'b1, 1'b0);
         return;
      end
      if (it.flags_in & tcte_pkg::FLAG_ACK) begin
         nxt = slot_snd[r] + ((slot_pay[r] == 0) ? 32'd1 : {16'd0, slot_pay[r]});
         if (it.ack_in[15:0] == nxt[15:0]) begin
            slot_age[r] = '0;
            slot_snd[r] = nxt;
         end
      end
      if (it.flags_in & tcte_pkg::FLAG_FIN) begin
         if (slot_state[r] == tcte_pkg::ST_CW) begin
            slot_flags[r] = tcte_pkg::FLAG_ACK; slot_rcv[r] = it.seq_in + 32'd1;
            slot_state[r] = tcte_pkg::ST_FREE;
            send_header(r, 1'b0, 1'b0);
            return;
         end
         slot_rcv[r] = slot_rcv[r] + 32'd1;
         slot_flags[r] = tcte_pkg::FLAG_ACK | tcte_pkg::FLAG_FIN;
         slot_state[r] = tcte_pkg::ST_CW;
         send_header(r, 1'b1, 1'b0);
         return;
      end else if (slot_state[r] == tcte_pkg::ST_CW) begin
         slot_state[r] = tcte_pkg::ST_FREE;
         send_header(r, 1'b0, 1'b0);
         return;
      end
      if (it.payload_len != 0 && slot_rcv[r] == it.seq_in) begin
         slot_rcv[r] = slot_rcv[r] + {16'd0, it.payload_len};
         if (it.data_taken) begin
            emit(tcte_pkg::KIND_NOTICE, r, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
         end else if (slot_age[r] != 0) begin
            slot_snd[0] = slot_snd[r]; slot_rcv[0] = slot_rcv[r];
            slot_flags[0] = tcte_pkg::FLAG_ACK;
            slot_addr[0] = it.src_addr; slot_rport[0] = it.remote_port;
            slot_lport[0] = it.local_port;
            slot_written[0] = 1'b1;
            send_header(0, 1'b0, 1'b1);
         end else begin
            slot_flags[r] = tcte_pkg::FLAG_ACK;
            send_header(r, 1'b0, 1'b1);
         end
         return;
      end
      emit(tcte_pkg::KIND_NONE, r, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
   endfunction

   function automatic void tick_all();
      logic drop;
      for (int i = 0; i < NS; i++) begin
         if (slot_state[i] == tcte_pkg::ST_FREE || slot_age[i] == 0) continue;
         if (slot_age[i] != 16'hFFFF) slot_age[i]++;
         if (slot_age[i] <= cfg_resend) continue;
         if (slot_state[i] == tcte_pkg::ST_CW) begin
            slot_state[i] = tcte_pkg::ST_FREE;
            emit(tcte_pkg::KIND_NOTICE, i, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0);
            continue;
         end
         slot_age[i] = 16'd1;
         drop = slot_retries[i] > cfg_retries;
         if (slot_retries[i] != 8'hFF) slot_retries[i]++;
         if (drop) slot_state[i] = tcte_pkg::ST_FREE;
         emit(tcte_pkg::KIND_RESEND, i, slot_flags[i], '0, '0, slot_lport[i], slot_rport[i],
              slot_addr[i], drop, 1'b0);
      end
   endfunction

   function automatic void predict_headers(tcte_pkg::req_type it);
      int c;
      batch_q.delete();
      c = int'(it.conn);
      case (it.op)
         tcte_pkg::OP_SEGMENT: segment_rx(it);
         tcte_pkg::OP_TICK: tick_all();
         tcte_pkg::OP_WRITTEN: begin
            slot_flags[c] = it.write_flags;
            send_header(c, 1'b0, 1'b0);
            slot_pay[c] = it.payload_len;
         end
         default: begin
            if (slot_state[c] == tcte_pkg::ST_FREE || slot_state[c] == tcte_pkg::ST_CW)
               emit(tcte_pkg::KIND_NONE, c, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
            else begin
               slot_flags[c] = tcte_pkg::FLAG_FIN | tcte_pkg::FLAG_ACK;
               slot_state[c] = tcte_pkg::ST_CW;
               slot_age[c] = '0;
               send_header(c, 1'b0, 1'b0);
            end
         end
      endcase
      if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
      foreach (batch_q[k]) header_q.push_back(batch_q[k]);
   endfunction

   // stimulus builders
   function automatic tcte_pkg::req_type any_item();
      tcte_pkg::req_type it;
      it.op = 2'($urandom); it.src_addr = $urandom; it.local_port = 16'($urandom);
      it.remote_port = 16'($urandom); it.seq_in = $urandom; it.ack_in = $urandom;
      it.flags_in = 8'($urandom); it.payload_len = 16'($urandom);
      it.syn_slot = 3'($urandom); it.data_taken = 1'($urandom); it.conn = 3'($urandom);
      it.write_flags = 8'($urandom);
      return it;
   endfunction

   function automatic tcte_pkg::req_type syn_item(int grant);
      tcte_pkg::req_type it;
      it = any_item();
      it.op = tcte_pkg::OP_SEGMENT;
      it.flags_in = tcte_pkg::FLAG_SYN | ($urandom_range(0, 1) ? tcte_pkg::FLAG_ACK : 8'h00);
      it.syn_slot = 3'(grant);
      it.src_addr = ($urandom_range(0, 2) == 0) ? $urandom :
                    32'h0A000000 | $urandom_range(0, 3);
      it.local_port = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd80;
      it.remote_port = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                       16'($urandom_range(1000, 1003));
      return it;
   endfunction

   function automatic tcte_pkg::req_type conn_item(int s, logic [7:0] fl, bit good);
      tcte_pkg::req_type it;
      logic [31:0] nxt;
      it = any_item();
      it.op = tcte_pkg::OP_SEGMENT;
      it.src_addr = slot_addr[s]; it.local_port = slot_lport[s];
      it.remote_port = slot_rport[s];
      it.flags_in = fl;
      nxt = slot_snd[s] + ((slot_pay[s] == 0) ? 32'd1 : {16'd0, slot_pay[s]});
      it.ack_in = good ? nxt + ($urandom_range(0, 3) == 0 ? 32'h10000 : 32'd0) : nxt + 32'd1;
      it.seq_in = good ? slot_rcv[s] : $urandom;
      it.payload_len = $urandom_range(0, 4) == 0 ? 16'd0 : 16'($urandom_range(1, 1500));
      return it;
   endfunction

   function automatic tcte_pkg::req_type op_item(logic [1:0] op, int c);
      tcte_pkg::req_type it;
      it = any_item();
      it.op = op;
      it.conn = 3'(c);
      if (op == tcte_pkg::OP_WRITTEN) it.payload_len = 16'($urandom_range(0, 2000));
      return it;
   endfunction

   function automatic int pick_active();
      int list[$];
      for (int i = 1; i < NS; i++) if (slot_state[i] != tcte_pkg::ST_FREE) list.push_back(i);
      if (list.size() == 0) return 0;
      return list[$urandom_range(0, list.size() - 1)];
   endfunction

   function automatic int pick_written();
      int list[$];
      for (int i = 0; i < NS; i++) if (slot_written[i]) list.push_back(i);
      if (list.size() == 0) return -1;
      return list[$urandom_range(0, list.size() - 1)];
   endfunction

   function automatic tcte_pkg::req_type random_item();
      int sel, s;
      logic [7:0] fl;
      sel = $urandom_range(0, 99);
      s = pick_active();
      if (sel < 40 && s != 0) begin
         case ($urandom_range(0, 7))
            0: fl = tcte_pkg::FLAG_RST;
            1, 2: fl = tcte_pkg::FLAG_ACK | tcte_pkg::FLAG_PSH;
            3: fl = tcte_pkg::FLAG_ACK | tcte_pkg::FLAG_FIN;
            4: fl = tcte_pkg::FLAG_FIN;
            5: fl = tcte_pkg::FLAG_ACK;
            default: fl = 8'($urandom) & ~tcte_pkg::FLAG_SYN;
         endcase
         return conn_item(s, fl, $urandom_range(0, 4) != 0);
      end
      if (sel < 55) return syn_item($urandom_range(0, NS - 1));
      if (sel < 75) return op_item(tcte_pkg::OP_TICK, 0);
      if (sel < 85) begin
         s = pick_written();
         if (s >= 0) return op_item(tcte_pkg::OP_WRITTEN, s);
         return op_item(tcte_pkg::OP_TICK, 0);
      end
      if (sel < 92) return op_item(tcte_pkg::OP_CLOSE, $urandom_range(0, NS - 1));
      begin
         tcte_pkg::req_type it;
         it = any_item();
         it.op = tcte_pkg::OP_SEGMENT;
         return it;
      end
   endfunction

   // clock, driver, receiver, checker
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_cnt > 0) begin
            gap_cnt--;
            req_if.valid <= 1'b0;
         end else if (pend_q.size() > 0) begin
            tcte_pkg::req_type it;
            it = pend_q.pop_front();
            req_if.valid <= 1'b1;
            req_if.op <= it.op; req_if.src_addr <= it.src_addr;
            req_if.local_port <= it.local_port; req_if.remote_port <= it.remote_port;
            req_if.seq_in <= it.seq_in; req_if.ack_in <= it.ack_in;
            req_if.flags_in <= it.flags_in; req_if.payload_len <= it.payload_len;
            req_if.syn_slot <= it.syn_slot; req_if.data_taken <= it.data_taken;
            req_if.conn <= it.conn; req_if.write_flags <= it.write_flags;
            if (burst_cnt == 0) begin
               burst_cnt = $urandom_range(1, 6);
               gap_cnt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            end else begin
               burst_cnt--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_req > 0 && hold_cnt == 0) begin
         hold_cnt = hold_req;
         hold_req = 0;
         rsp_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, stall_mode) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         tcte_pkg::req_type it;
         it.op = req_if.op; it.src_addr = req_if.src_addr;
         it.local_port = req_if.local_port; it.remote_port = req_if.remote_port;
         it.seq_in = req_if.seq_in; it.ack_in = req_if.ack_in;
         it.flags_in = req_if.flags_in; it.payload_len = req_if.payload_len;
         it.syn_slot = req_if.syn_slot; it.data_taken = req_if.data_taken;
         it.conn = req_if.conn; it.write_flags = req_if.write_flags;
         predict_headers(it);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tcte_pkg::rsp_type got, want;
         got.kind = rsp_if.kind; got.slot = rsp_if.slot; got.flags_out = rsp_if.flags_out;
         got.seq_out = rsp_if.seq_out; got.ack_out = rsp_if.ack_out;
         got.our_port = rsp_if.our_port; got.peer_port = rsp_if.peer_port;
         got.peer_addr = rsp_if.peer_addr; got.closing = rsp_if.closing;
         got.deliver = rsp_if.deliver; got.last = rsp_if.last;
         if (header_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected transaction kind=%0d slot=%0d", got.kind, got.slot);
         end else begin
            want = header_q.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot ||
                got.flags_out !== want.flags_out || got.seq_out !== want.seq_out ||
                got.ack_out !== want.ack_out || got.our_port !== want.our_port ||
                got.peer_port !== want.peer_port || got.peer_addr !== want.peer_addr ||
                got.closing !== want.closing || got.deliver !== want.deliver ||
                got.last !== want.last) begin
               errors++;
               if (errors <= 10) begin
                  $display("ERROR: mismatch at %0t", $realtime);
                  $display({"  exp kind=%0d slot=%0d fl=%h seq=%h ack=%h op=%h pp=%h",
                            " pa=%h cl=%b dv=%b last=%b"},
                           want.kind, want.slot, want.flags_out, want.seq_out, want.ack_out,
                           want.our_port, want.peer_port, want.peer_addr, want.closing,
                           want.deliver, want.last);
                  $display({"  got kind=%0d slot=%0d fl=%h seq=%h ack=%h op=%h pp=%h",
                            " pa=%h cl=%b dv=%b last=%b"},
                           got.kind, got.slot, got.flags_out, got.seq_out, got.ack_out,
                           got.our_port, got.peer_port, got.peer_addr, got.closing,
                           got.deliver, got.last);
               end
            end
         end
      end
   end

   // stimulus sequencing
   task automatic wait_free();
      do begin
         @(posedge clock);
         #1;
      end while (pend_q.size() > 0 || req_if.valid);
   endtask

   task automatic push(tcte_pkg::req_type it);
      wait_free();
      pend_q.push_back(it);
   endtask

   task automatic drain();
      wait_free();
      do begin
         @(posedge clock);
         #1;
      end while (header_q.size() > 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == tcte_pkg::CSR_RESEND_TICKS) cfg_resend = val;
      else cfg_retries = val[7:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) push(random_item());
   endtask

   initial begin
      tcte_pkg::req_type it;
      errors = 0; gap_cnt = 0; burst_cnt = 0; hold_cnt = 0; hold_req = 0; stall_mode = 0;
      cfg_resend = tcte_pkg::RESEND_TICKS_RST;
      cfg_retries = tcte_pkg::RETRY_LIMIT_RST;
      for (int i = 0; i < NS; i++) begin
         slot_state[i] = tcte_pkg::ST_FREE; slot_lport[i] = '0; slot_rport[i] = '0;
         slot_addr[i] = '0; slot_snd[i] = '0; slot_rcv[i] = '0; slot_flags[i] = '0;
         slot_pay[i] = '0; slot_age[i] = '0; slot_retries[i] = '0; slot_written[i] = 1'b0;
      end
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_if.valid = 1'b0; rsp_if.ready = 1'b0;
      req_if.op = '0; req_if.src_addr = '0; req_if.local_port = '0;
      req_if.remote_port = '0; req_if.seq_in = '0; req_if.ack_in = '0;
      req_if.flags_in = '0; req_if.payload_len = '0; req_if.syn_slot = '0;
      req_if.data_taken = '0; req_if.conn = '0; req_if.write_flags = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_csr(tcte_pkg::CSR_RESEND_TICKS, 16'd3);
      write_csr(tcte_pkg::CSR_RETRY_LIMIT, 16'd1);

      // directed
      it = syn_item(1);
      it.src_addr = '1; it.local_port = '1; it.remote_port = '1; it.seq_in = '1;
      push(it);
      it = syn_item(7);
      it.src_addr = '0; it.local_port = '0; it.remote_port = '0; it.seq_in = '0;
      push(it);
      push(syn_item(0));
      it = any_item(); it.op = tcte_pkg::OP_SEGMENT; it.flags_in = tcte_pkg::FLAG_PSH;
      it.src_addr = 32'h5;
      push(it);
      it = any_item(); it.op = tcte_pkg::OP_SEGMENT; it.flags_in = tcte_pkg::FLAG_ACK;
      it.src_addr = 32'h5;
      push(it);
      push(op_item(tcte_pkg::OP_WRITTEN, 0));
      wait_free(); push(conn_item(1, tcte_pkg::FLAG_ACK, 1'b1));
      wait_free(); it = conn_item(1, tcte_pkg::FLAG_ACK | tcte_pkg::FLAG_PSH, 1'b1);
      it.data_taken = 1'b1; push(it);
      wait_free(); it = conn_item(1, tcte_pkg::FLAG_PSH, 1'b1); it.data_taken = 1'b0;
      push(it);
      wait_free(); it = conn_item(7, tcte_pkg::FLAG_PSH, 1'b1); it.data_taken = 1'b0;
      push(it);
      it = op_item(tcte_pkg::OP_WRITTEN, 1);
      it.write_flags = tcte_pkg::FLAG_PSH | tcte_pkg::FLAG_ACK;
      it.payload_len = 16'hFFFF; push(it);
      for (int i = 0; i < 6; i++) push(op_item(tcte_pkg::OP_TICK, 0));
      push(op_item(tcte_pkg::OP_CLOSE, 1));
      push(op_item(tcte_pkg::OP_CLOSE, 1));
      push(op_item(tcte_pkg::OP_CLOSE, 0));
      wait_free(); push(conn_item(7, tcte_pkg::FLAG_FIN | tcte_pkg::FLAG_ACK, 1'b1));
      wait_free(); push(conn_item(7, tcte_pkg::FLAG_FIN, 1'b1));
      push(syn_item(2));
      wait_free(); push(conn_item(2, tcte_pkg::FLAG_RST, 1'b0));
      for (int i = 0; i < 5; i++) push(op_item(tcte_pkg::OP_TICK, 0));
      drain();

      write_csr(tcte_pkg::CSR_RESEND_TICKS, 16'd1);
      write_csr(tcte_pkg::CSR_RETRY_LIMIT, 16'd0);
      stall_mode = 2;
      random_phase(35);
      drain();

      write_csr(tcte_pkg::CSR_RESEND_TICKS, 16'hFFFF);
      write_csr(tcte_pkg::CSR_RETRY_LIMIT, 16'h00FF);
      stall_mode = 0;
      hold_req = 300;
      random_phase(35);
      drain();

      write_csr(tcte_pkg::CSR_RESEND_TICKS, 16'd2);
      write_csr(tcte_pkg::CSR_RETRY_LIMIT, 16'd3);
      stall_mode = 1;
      random_phase(35);
      drain();

      // keep one connection retransmitting on every tick
      write_csr(tcte_pkg::CSR_RESEND_TICKS, 16'd1);
      write_csr(tcte_pkg::CSR_RETRY_LIMIT, 16'h00FF);
      stall_mode = 3;
      push(syn_item(3));
      for (int i = 0; i < 30; i++) push(op_item(tcte_pkg::OP_TICK, 0));
      random_phase(35);
      drain();

      if (errors == 0 && header_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[tcp_connection_table_engine.f]
rtl/tcte_pkg.sv
rtl/tcte_req_if.sv
rtl/tcte_rsp_if.sv
rtl/tcp_connection_table_engine.sv
verif/tb_top.sv
